@@ rtl/ipv4_frt_pkg.sv @@
package ipv4_frt_pkg;

    localparam int MAX_STREAMS   = 128;
    localparam int MAX_FRAGMENTS = 64;
    localparam int SW            = $clog2(MAX_STREAMS);
    localparam int FW            = $clog2(MAX_FRAGMENTS);
    localparam int CW            = FW + 1;
    localparam int LW            = SW + 1;

    localparam logic [31:0] TIMEOUT_RST = 32'd2000000;
    localparam logic [7:0]  PURGE_RST   = 8'd100;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_PURGE   = 1'b1;

    typedef enum logic [1:0] {
        ST_NOFRAG = 2'd0,
        ST_HELD   = 2'd1,
        ST_DONE   = 2'd2,
        ST_DROP   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PURGE_RD,
        S_PURGE_CHK,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_HDR,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_CHECK_RD,
        S_CHECK_CHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [47:0] last;
        logic [22:0] received;
        logic [16:0] total;
        logic        end_seen;
        logic [CW-1:0] count;
    } t_stream;

endpackage

@@ rtl/ipv4_fragment_reassembly_tracker_unit.sv @@
// IPv4 fragment reassembly tracker.
// Input channel: one header summary per request (i_valid / o_stall). Output
// channel: one status and length per request (o_valid / i_stall).
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index (0 timeout_us,
// 1 purge_limit) and i_cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce (o_cfg_ready is 1).
// One request is processed at a time; a new one is taken once the previous
// result has left the output register.
// An unfragmented request goes straight to the output. A fragment first
// takes a purge sweep of all 128 stream entries when live streams exceed
// the purge limit, then a key search of the stream table memory, then a
// scan to find the insert point and shift the fragment list (up to 64
// entries), and, when all bytes are in, a contiguity check (fragment memory, one port).
// Reset empties the stream table (valid flags in flip-flops) and restores
// the register defaults. A stalled result is held in the output register
// and blocks the next request until taken.
module ipv4_fragment_reassembly_tracker_unit
    import ipv4_frt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_has_payload,
    input  logic [47:0] i_time_us,
    input  logic [15:0] i_ident,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [12:0] i_offset_units,
    input  logic        i_more_fragments,
    input  logic [15:0] i_payload_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [16:0] o_total_len,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [31:0] r_timeout;
    logic [7:0]  r_purge;
    logic [MAX_STREAMS-1:0] r_svalid;
    logic [LW-1:0] r_live;

    t_stream stbl [MAX_STREAMS];
    logic [31:0] ftbl [MAX_STREAMS*MAX_FRAGMENTS];

    logic [47:0] r_now;
    logic [15:0] r_ident;
    logic [31:0] r_lo, r_hi;
    logic [15:0] r_off, r_len;
    logic        r_mf;

    logic [LW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_slot, n_slot;
    logic          r_free_ok, n_free_ok;
    logic [SW-1:0] r_free, n_free;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_j, n_j;
    logic [16:0]   r_exp, n_exp;
    logic          r_ok, n_ok;
    t_stream       r_cur, n_cur;

    logic [1:0]  r_ostat, n_ostat;
    logic [16:0] r_olen, n_olen;
    logic        r_ovalid;

    t_stream     r_s_rd;
    logic [31:0] r_f_rd;

    logic          s_we;
    logic [SW-1:0] s_addr;
    t_stream       s_wd;
    logic          f_we;
    logic [SW+FW-1:0] f_addr;
    logic [31:0]   f_wd;

    logic          clr_v, set_v;
    logic [SW-1:0] v_addr;

    logic accept;
    logic [47:0] age;
    logic stale;
    logic [CW-1:0] nfr;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostat;
    assign o_total_len = r_olen;

    assign age   = (r_now >= r_s_rd.last) ? (r_now - r_s_rd.last) : 48'd0;
    assign stale = age > {16'd0, r_timeout};
    assign nfr   = (r_cur.count > CW'(MAX_FRAGMENTS)) ? CW'(MAX_FRAGMENTS) : r_cur.count;

    always_ff @(posedge i_clk) begin
        if (s_we) stbl[s_addr] <= s_wd;
        r_s_rd <= stbl[s_addr];
        if (f_we) ftbl[f_addr] <= f_wd;
        r_f_rd <= ftbl[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_timeout <= TIMEOUT_RST;
            r_purge  <= PURGE_RST;
            r_svalid <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_PURGE:   r_purge   <= i_cfg_data[7:0];
                    default:     r_timeout <= r_timeout;
                endcase
            end
            if (clr_v && r_svalid[v_addr]) begin
                r_svalid[v_addr] <= 1'b0;
                r_live <= r_live - 1'b1;
            end else if (set_v) begin
                r_svalid[v_addr] <= 1'b1;
                r_live <= r_live + 1'b1;
            end
            if (n_state == S_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_slot <= n_slot;
        r_free_ok <= n_free_ok; r_free <= n_free; r_pos <= n_pos; r_j <= n_j;
        r_exp <= n_exp; r_ok <= n_ok; r_cur <= n_cur;
        r_ostat <= n_ostat; r_olen <= n_olen;
        if (accept) begin
            r_now   <= i_time_us;
            r_ident <= i_ident;
            r_lo    <= (i_src_addr < i_dst_addr) ? i_src_addr : i_dst_addr;
            r_hi    <= (i_src_addr < i_dst_addr) ? i_dst_addr : i_src_addr;
            r_off   <= {i_offset_units, 3'b000};
            r_len   <= i_payload_len;
            r_mf    <= i_more_fragments;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx; n_slot = r_slot;
        n_free_ok = r_free_ok; n_free = r_free; n_pos = r_pos; n_j = r_j;
        n_exp = r_exp; n_ok = r_ok; n_cur = r_cur;
        n_ostat = r_ostat; n_olen = r_olen;
        s_we = 1'b0; s_addr = r_idx[SW-1:0]; s_wd = r_cur;
        f_we = 1'b0; f_addr = {r_slot, r_j[FW-1:0]}; f_wd = '0;
        clr_v = 1'b0; set_v = 1'b0; v_addr = r_idx[SW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0; n_free_ok = 1'b0;
                    if (!i_has_payload || (!i_more_fragments && i_offset_units == '0)) begin
                        n_ostat = ST_NOFRAG; n_olen = '0; n_state = S_OUT;
                    end else if ({1'b0, r_live} > {1'b0, r_purge}) begin
                        n_state = S_PURGE_RD;
                    end else begin
                        n_state = S_LOOK_RD;
                    end
                end
            end
            S_PURGE_RD: n_state = S_PURGE_CHK;
            S_PURGE_CHK: begin
                if (r_svalid[r_idx[SW-1:0]] && stale) clr_v = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == LW'(MAX_STREAMS - 1)) begin
                    n_idx = '0; n_state = S_LOOK_RD;
                end else n_state = S_PURGE_RD;
            end
            S_LOOK_RD: n_state = S_LOOK_CHK;
            S_LOOK_CHK: begin
                n_idx = r_idx + 1'b1;
                n_state = S_LOOK_RD;
                if (!r_svalid[r_idx[SW-1:0]] && !r_free_ok) begin
                    n_free_ok = 1'b1; n_free = r_idx[SW-1:0];
                end
                if (r_svalid[r_idx[SW-1:0]] && r_s_rd.ident == r_ident &&
                    r_s_rd.lo == r_lo && r_s_rd.hi == r_hi) begin
                    n_slot = r_idx[SW-1:0];
                    n_cur = r_s_rd;
                    if (r_s_rd.count != '0 && stale) begin
                        n_cur.received = '0; n_cur.total = '0;
                        n_cur.end_seen = 1'b0; n_cur.count = '0;
                    end
                    n_cur.last = r_now;
                    n_state = S_HDR;
                end else if (r_idx == LW'(MAX_STREAMS - 1)) begin
                    n_state = S_HDR;
                    if (!r_svalid[r_idx[SW-1:0]] || r_free_ok) begin
                        n_slot = (!r_free_ok) ? r_idx[SW-1:0] : r_free;
                        n_cur.ident = r_ident; n_cur.lo = r_lo; n_cur.hi = r_hi;
                        n_cur.received = '0; n_cur.total = '0;
                        n_cur.end_seen = 1'b0; n_cur.count = '0;
                        n_cur.last = r_now;
                        set_v = 1'b1;
                        v_addr = (!r_free_ok) ? r_idx[SW-1:0] : r_free;
                    end else begin
                        n_ostat = ST_DROP; n_olen = '0; n_state = S_OUT;
                    end
                end
            end
            S_HDR: begin
                s_we = 1'b1; s_addr = r_slot;
                n_j = '0; n_pos = '0;
                n_state = (nfr == '0) ? S_SHIFT_RD : S_FIND_RD;
                if (nfr == '0) n_j = '0;
            end
            S_FIND_RD: n_state = S_FIND_CHK;
            S_FIND_CHK: begin
                if (r_off > r_f_rd[31:16]) begin
                    n_j = r_j + 1'b1;
                    n_pos = r_j + 1'b1;
                    n_state = (r_j + 1'b1 >= nfr) ? S_SHIFT_RD : S_FIND_RD;
                    if (r_j + 1'b1 >= nfr) n_j = nfr;
                end else if (r_f_rd[31:16] == r_off) begin
                    f_we = 1'b1; f_wd = {r_off, r_len};
                    n_state = S_INSERT;
                    n_pos = '1;
                end else begin
                    n_pos = r_j; n_j = nfr; n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (nfr >= CW'(MAX_FRAGMENTS)) begin
                    n_ostat = ST_DROP; n_olen = '0; n_state = S_OUT;
                end else if (r_j > r_pos) begin
                    f_addr = {r_slot, FW'(r_j - 1'b1)};
                    n_state = S_SHIFT_WR;
                end else begin
                    f_we = 1'b1; f_addr = {r_slot, r_pos[FW-1:0]};
                    f_wd = {r_off, r_len};
                    n_cur.count = nfr + 1'b1;
                    n_cur.received = r_cur.received + 23'(r_len);
                    n_pos = '0;
                    n_state = S_INSERT;
                end
            end
            S_SHIFT_WR: begin
                f_we = 1'b1; f_wd = r_f_rd;
                n_j = r_j - 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_INSERT: begin
                if (!r_mf) begin
                    n_cur.total = 17'(r_off) + 17'(r_len);
                    n_cur.end_seen = 1'b1;
                end
                s_we = 1'b1; s_addr = r_slot;
                if (!r_mf) begin
                    s_wd.total = 17'(r_off) + 17'(r_len);
                    s_wd.end_seen = 1'b1;
                end
                n_j = '0; n_exp = '0; n_ok = 1'b1;
                n_ostat = ST_HELD; n_olen = '0;
                if ((!r_mf || r_cur.end_seen) &&
                    r_cur.received == 23'(r_mf ? r_cur.total : 17'(r_off) + 17'(r_len)))
                    n_state = S_CHECK_RD;
                else n_state = S_OUT;
            end
            S_CHECK_RD: n_state = S_CHECK_CHK;
            S_CHECK_CHK: begin
                if (r_j == '0 && r_f_rd[31:16] != '0) begin
                    n_state = S_OUT;
                end else begin
                    if ({1'b0, r_f_rd[31:16]} != r_exp) n_ok = 1'b0;
                    n_exp = 17'(r_f_rd[31:16]) + 17'(r_f_rd[15:0]);
                    n_j = r_j + 1'b1;
                    if (r_j + 1'b1 >= r_cur.count || {1'b0, r_f_rd[31:16]} != r_exp) begin
                        clr_v = 1'b1; v_addr = r_slot;
                        if ({1'b0, r_f_rd[31:16]} == r_exp && r_ok) begin
                            n_ostat = ST_DONE; n_olen = r_cur.total;
                        end
                        n_state = S_OUT;
                    end else n_state = S_CHECK_RD;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(o_status));
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("busy without stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && o_status != ST_DONE |-> o_total_len == '0)
        else $error("length on non-done result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == LW'($countones(r_svalid))) else $error("live count mismatch");

endmodule
